/* rtl/opw_pkg.sv */
// Shared types and constants of the OpenPGP packet walker.
`default_nettype none

package opw_pkg;

  // Width of the internal packet counter; it saturates at all ones.
  localparam int unsigned COUNT_WIDTH = 32;

  localparam int unsigned LEN_STORE_DEPTH = 5;

  // First length octet thresholds of the new packet format.
  localparam logic [7:0] OCT_TWO_LO  = 8'd192;
  localparam logic [7:0] OCT_PART_LO = 8'd224;
  localparam logic [7:0] OCT_FIVE    = 8'd255;

  // Old-format length type that marks an indeterminate length.
  localparam logic [1:0] OLD_LEN_INDET = 2'd3;

  typedef enum logic [3:0] {
    PH_TAG  = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_REST = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_TAG     = 3'd0,
    ROLE_LEN     = 3'd1,
    ROLE_BODY    = 3'd2,
    ROLE_REST    = 3'd3,
    ROLE_IGNORED = 3'd4
  } role_e;

  typedef struct packed {
    role_e       byte_role;
    logic [5:0]  packet_tag;
    logic        error_flag;
    logic        stream_complete;
    logic [31:0] packets_seen;
    logic [5:0]  opening_tag;
    logic [31:0] body_left;
    logic        end_marker;
  } result_t;

endpackage

`default_nettype wire

/* rtl/opw_if.sv */
// Handshake interfaces for the byte stream and the per-byte status.
`default_nettype none

interface opw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_stream;

  modport source (output valid, output data_byte, output last_of_stream, input ready);
  modport sink (input valid, input data_byte, input last_of_stream, output ready);
endinterface

interface opw_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [5:0]  packet_tag;
  logic        error_flag;
  logic        stream_complete;
  logic [31:0] packets_seen;
  logic [5:0]  opening_tag;
  logic [31:0] body_left;
  logic        end_marker;

  modport source (output valid, output byte_role, output packet_tag, output error_flag,
                  output stream_complete, output packets_seen, output opening_tag,
                  output body_left, output end_marker, input ready);
  modport sink (input valid, input byte_role, input packet_tag, input error_flag,
                input stream_complete, input packets_seen, input opening_tag,
                input body_left, input end_marker, output ready);
endinterface

`default_nettype wire

/* rtl/opw_core.sv */
// Walker state and the per-byte header decode.
`default_nettype none

module opw_core
  import opw_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  output result_t         res_o
);

  phase_e                 phase_q, phase_d;
  logic                   nf_q, nf_d;
  logic                   part_q, part_d;
  logic [2:0]             collected_q, collected_d;
  logic [2:0]             needed_q, needed_d;
  logic [31:0]            chunk_q, chunk_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [5:0]             first_tag_q, first_tag_d;
  logic                   error_q, error_d;

  logic [7:0]  len_q [LEN_STORE_DEPTH];
  logic        store_we;

  logic [7:0]  oct [LEN_STORE_DEPTH];
  logic [31:0] len_new;
  logic        part_new;
  logic [2:0]  needed_new;
  logic [2:0]  collected_inc;
  logic [31:0] chunk_dec;
  logic [5:0]  tag;
  logic        nf_byte;
  logic [63:0] cnt_wide;

  // Length octets as they stand once the current byte is stored.
  always_comb begin
    for (int i = 0; i < LEN_STORE_DEPTH; i++) begin
      oct[i] = (3'(i) == collected_q) ? data_byte_i : len_q[i];
    end
  end

  always_comb begin
    part_new = 1'b0;
    if (nf_q) begin
      if (oct[0] < OCT_TWO_LO) begin
        len_new = {24'd0, oct[0]};
      end else if (oct[0] < OCT_PART_LO) begin
        len_new = {16'd0, oct[0] - OCT_TWO_LO, 8'd0} + {24'd0, oct[1]} + 32'd192;
      end else if (oct[0] == OCT_FIVE) begin
        len_new = {oct[1], oct[2], oct[3], oct[4]};
      end else begin
        len_new  = 32'd1 << oct[0][4:0];
        part_new = 1'b1;
      end
    end else begin
      case (needed_q)
        3'd1:    len_new = {24'd0, oct[0]};
        3'd2:    len_new = {16'd0, oct[0], oct[1]};
        default: len_new = {oct[0], oct[1], oct[2], oct[3]};
      endcase
    end
  end

  assign collected_inc = collected_q + 3'd1;
  assign chunk_dec     = (chunk_q != 32'd0) ? chunk_q - 32'd1 : chunk_q;
  assign nf_byte       = data_byte_i[6];
  assign tag           = nf_byte ? data_byte_i[5:0] : {2'b00, data_byte_i[5:2]};

  always_comb begin
    if (data_byte_i < OCT_TWO_LO || (data_byte_i >= OCT_PART_LO && data_byte_i < OCT_FIVE)) begin
      needed_new = 3'd1;
    end else if (data_byte_i < OCT_PART_LO) begin
      needed_new = 3'd2;
    end else begin
      needed_new = 3'd5;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    nf_d        = nf_q;
    part_d      = part_q;
    collected_d = collected_q;
    needed_d    = needed_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    first_tag_d = first_tag_q;
    error_d     = error_q;
    store_we    = 1'b0;
    res_o       = '0;
    res_o.byte_role = ROLE_IGNORED;

    if (!error_q) begin
      unique case (phase_q)
        PH_REST: res_o.byte_role = ROLE_REST;
        PH_BODY: begin
          res_o.byte_role = ROLE_BODY;
          chunk_d = chunk_dec;
          if (chunk_dec == 32'd0) begin
            if (part_q) begin
              phase_d     = PH_LEN;
              collected_d = 3'd0;
              needed_d    = 3'd0;
            end else begin
              phase_d = PH_TAG;
            end
          end
        end
        PH_TAG: begin
          res_o.byte_role = ROLE_TAG;
          if (!data_byte_i[7]) begin
            error_d = 1'b1;
          end else begin
            nf_d = nf_byte;
            if (tag == 6'd0) begin
              error_d = 1'b1;
            end else begin
              res_o.packet_tag = tag;
              if (cnt_q == '0) first_tag_d = tag;
              if (cnt_q != '1) cnt_d = cnt_q + COUNT_WIDTH'(1);
              collected_d = 3'd0;
              part_d      = 1'b0;
              if (nf_byte) begin
                needed_d = 3'd0;
                phase_d  = PH_LEN;
              end else if (data_byte_i[1:0] == OLD_LEN_INDET) begin
                phase_d = PH_REST;
              end else begin
                needed_d = 3'd1 << data_byte_i[1:0];
                phase_d  = PH_LEN;
              end
            end
          end
        end
        PH_LEN: begin
          res_o.byte_role = ROLE_LEN;
          if (collected_q >= 3'(LEN_STORE_DEPTH)) begin
            error_d = 1'b1;
          end else begin
            store_we    = 1'b1;
            collected_d = collected_inc;
            if (nf_q && collected_q == 3'd0) needed_d = needed_new;
            if (collected_inc == needed_d) begin
              part_d  = part_new;
              chunk_d = len_new;
              phase_d = (len_new != 32'd0) ? PH_BODY : PH_TAG;
            end
          end
        end
        default: error_d = 1'b1;
      endcase
    end

    cnt_wide = 64'(cnt_d);
    res_o.error_flag       = error_d;
    res_o.stream_complete  = last_i && !error_d && (cnt_d != '0) &&
                             (phase_d == PH_TAG || phase_d == PH_REST);
    res_o.packets_seen     = (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                    : cnt_wide[31:0];
    res_o.opening_tag      = first_tag_d;
    res_o.body_left        = chunk_d;
    res_o.end_marker       = last_i;

    // The last byte of a stream re-arms the walker.
    if (last_i) begin
      phase_d     = PH_TAG;
      nf_d        = 1'b0;
      part_d      = 1'b0;
      collected_d = 3'd0;
      needed_d    = 3'd0;
      chunk_d     = 32'd0;
      cnt_d       = '0;
      first_tag_d = 6'd0;
      error_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      nf_q        <= 1'b0;
      part_q      <= 1'b0;
      collected_q <= 3'd0;
      needed_q    <= 3'd0;
      chunk_q     <= 32'd0;
      cnt_q       <= '0;
      first_tag_q <= 6'd0;
      error_q     <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      nf_q        <= nf_d;
      part_q      <= part_d;
      collected_q <= collected_d;
      needed_q    <= needed_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      first_tag_q <= first_tag_d;
      error_q     <= error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store_we) begin
      len_q[collected_q] <= data_byte_i;
    end
  end

  // The error holds until a last byte re-arms the walker.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (error_q && !(step_i && last_i)) |=> error_q)
    else $error("error flag cleared without end of stream");

  // The packet count only grows within a stream.
  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !last_i) |=> (cnt_q >= $past(cnt_q)))
    else $error("packet count went down within a stream");

  // A first tag is recorded exactly when a packet has been counted.
  a_first_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) == (first_tag_q != 6'd0))
    else $error("first tag and packet count disagree");

  a_collected_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    collected_q <= 3'(LEN_STORE_DEPTH))
    else $error("length octet count out of range");

endmodule

`default_nettype wire

/* rtl/openpgp_packet_walker.sv */
// Top level of the OpenPGP packet walker: byte intake, decode and status buffer.
//
//   Channel   Modport  Moves per request
//   byte_in_i sink     data_byte, last_of_stream
//   result_o  source   byte_role, packet_tag, error_flag, stream_complete,
//                      packets_seen, opening_tag, body_left, end_marker
//
// Each accepted byte is decoded in the cycle it is accepted and its status is
// registered. While result_o takes statuses, the block sustains one byte per
// cycle. A two-entry status buffer (output register plus skid register) lets a
// byte be taken while an earlier status still waits, so ready only falls once
// both entries are full. Reset (rst_ni low) clears the walker and empties the buffer.
`default_nettype none

module openpgp_packet_walker
  import opw_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  opw_byte_if.sink    byte_in_i,
  opw_result_if.source result_o
);

  logic    step;
  logic    pop;
  result_t res;

  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;

  // A new byte is taken whenever the skid register is free.
  assign byte_in_i.ready = !skid_valid_q;
  assign step = byte_in_i.valid && byte_in_i.ready;
  assign pop  = out_valid_q && result_o.ready;

  opw_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_in_i.data_byte),
    .last_i      (byte_in_i.last_of_stream),
    .res_o       (res)
  );

  // Status buffer: the output register always holds the oldest status.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (step) begin
        out_d = res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (step) begin
      if (out_valid_q) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end else begin
        out_d       = res;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.byte_role       = out_q.byte_role;
  assign result_o.packet_tag      = out_q.packet_tag;
  assign result_o.error_flag      = out_q.error_flag;
  assign result_o.stream_complete = out_q.stream_complete;
  assign result_o.packets_seen    = out_q.packets_seen;
  assign result_o.opening_tag     = out_q.opening_tag;
  assign result_o.body_left       = out_q.body_left;
  assign result_o.end_marker      = out_q.end_marker;

  // The skid register is only filled behind a waiting output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without an output entry");

  // An accepted byte always produces a status in the next cycle.
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted byte left no status");

  // A waiting status holds still until it is taken.
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> (out_valid_q && $stable(out_q)))
    else $error("waiting status changed before it was taken");

endmodule

`default_nettype wire
